/* src/wbps_pkg.sv */
// Shared types and constants of the wildcard byte pattern scanner.
package wbps_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int PAT_BYTES       = 16;
	localparam int LEN_W           = 5;
	localparam int ADDR_W          = 48;
	localparam int BYTE_W          = 8;
	localparam int APB_DATA_W      = 64;
	localparam int APB_ADDR_W      = 6;
	localparam int REG_ALIGN       = 3;
	localparam int REG_IDX_W       = APB_ADDR_W - REG_ALIGN;

	localparam logic [LEN_W-1:0]  PATTERN_LEN_RESET = LEN_W'(1);
	localparam logic [ADDR_W-1:0] ADDR_MAX          = '1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PATTERN_LEN  = 3'd0,
		REG_PATTERN_LOW  = 3'd1,
		REG_PATTERN_HIGH = 3'd2,
		REG_WILDCARD     = 3'd3,
		REG_BASE_ADDRESS = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [LEN_W-1:0]          pattern_len;
		logic [BYTE_W*PAT_BYTES-1:0] pattern;
		logic [PAT_BYTES-1:0]      wildcard_mask;
		logic [ADDR_W-1:0]         base_address;
	} cfg_t;

endpackage

/* src/wbps_ifs.sv */
// Valid/ready channel interfaces for the byte stream and the scan results.
interface wbps_byte_if;
	logic                       valid;
	logic                       ready;
	logic [wbps_pkg::BYTE_W-1:0] data_byte;
	logic                       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_result_if;
	logic                       valid;
	logic                       ready;
	logic                       match_found;
	logic [wbps_pkg::ADDR_W-1:0] match_address;
	logic                       region_done;

	modport source (output valid, output match_found, output match_address,
		output region_done, input ready);
	modport sink (input valid, input match_found, input match_address,
		input region_done, output ready);
endinterface

/* src/wbps_cfg_regs.sv */
// APB-style configuration register file of the scanner.
module wbps_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [wbps_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [wbps_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [wbps_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output wbps_pkg::cfg_t                      cfg
);

	wbps_pkg::reg_idx_t reg_idx;
	wbps_pkg::cfg_t     cfg_q;
	logic               wr_en;

	assign reg_idx = wbps_pkg::reg_idx_t'(paddr[wbps_pkg::APB_ADDR_W-1:wbps_pkg::REG_ALIGN]);
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_len   <= wbps_pkg::PATTERN_LEN_RESET;
			cfg_q.pattern       <= '0;
			cfg_q.wildcard_mask <= '0;
			cfg_q.base_address  <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				wbps_pkg::REG_PATTERN_LEN: begin
					cfg_q.pattern_len <= pwdata[wbps_pkg::LEN_W-1:0];
				end
				wbps_pkg::REG_PATTERN_LOW: begin
					cfg_q.pattern[wbps_pkg::APB_DATA_W-1:0] <= pwdata;
				end
				wbps_pkg::REG_PATTERN_HIGH: begin
					cfg_q.pattern[2*wbps_pkg::APB_DATA_W-1:wbps_pkg::APB_DATA_W] <= pwdata;
				end
				wbps_pkg::REG_WILDCARD: begin
					cfg_q.wildcard_mask <= pwdata[wbps_pkg::PAT_BYTES-1:0];
				end
				wbps_pkg::REG_BASE_ADDRESS: begin
					cfg_q.base_address <= pwdata[wbps_pkg::ADDR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			wbps_pkg::REG_PATTERN_LEN: begin
				prdata = wbps_pkg::APB_DATA_W'(cfg_q.pattern_len);
			end
			wbps_pkg::REG_PATTERN_LOW: begin
				prdata = cfg_q.pattern[wbps_pkg::APB_DATA_W-1:0];
			end
			wbps_pkg::REG_PATTERN_HIGH: begin
				prdata = cfg_q.pattern[2*wbps_pkg::APB_DATA_W-1:wbps_pkg::APB_DATA_W];
			end
			wbps_pkg::REG_WILDCARD: begin
				prdata = wbps_pkg::APB_DATA_W'(cfg_q.wildcard_mask);
			end
			wbps_pkg::REG_BASE_ADDRESS: begin
				prdata = wbps_pkg::APB_DATA_W'(cfg_q.base_address);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

/* src/wbps_matcher.sv */
// Byte history window and parallel wildcard compare against the pattern.
module wbps_matcher #(
	parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        shift_en,
	input  logic [wbps_pkg::BYTE_W-1:0]                 cur_byte,
	input  logic [wbps_pkg::BYTE_W*wbps_pkg::PAT_BYTES-1:0] pattern,
	input  logic [wbps_pkg::PAT_BYTES-1:0]              wildcard_mask,
	input  logic [wbps_pkg::LEN_W-1:0]                  len_eff,
	output logic                                        window_hit
);

	localparam int CAP = (PATTERN_MAX < wbps_pkg::PAT_BYTES) ? PATTERN_MAX
		: wbps_pkg::PAT_BYTES;
	localparam int WIN_DEPTH = CAP - 1;
	localparam int PI_W = $clog2(wbps_pkg::PAT_BYTES);

	logic [wbps_pkg::BYTE_W-1:0] window_q [WIN_DEPTH];
	logic [wbps_pkg::BYTE_W-1:0] tap [CAP];
	logic [wbps_pkg::LEN_W-1:0]  pat_idx [CAP];
	logic [CAP-1:0]              ok;

	// Most recent byte sits in entry zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN_DEPTH; k++) begin
				window_q[k] <= '0;
			end
		end else if (shift_en) begin
			window_q[0] <= cur_byte;
			for (int k = 1; k < WIN_DEPTH; k++) begin
				window_q[k] <= window_q[k-1];
			end
		end
	end

	// Tap d is the byte d places back from the current one; it lines up with
	// pattern byte len_eff-1-d.
	for (genvar d = 0; d < CAP; d++) begin : g_tap
		if (d == 0) begin : g_cur
			assign tap[d] = cur_byte;
		end else begin : g_win
			assign tap[d] = window_q[d-1];
		end
		assign pat_idx[d] = len_eff - wbps_pkg::LEN_W'(d) - wbps_pkg::LEN_W'(1);
		assign ok[d] = (wbps_pkg::LEN_W'(d) >= len_eff)
			|| wildcard_mask[pat_idx[d][PI_W-1:0]]
			|| (tap[d] == pattern[{pat_idx[d][PI_W-1:0], 3'b000} +: wbps_pkg::BYTE_W]);
	end

	assign window_hit = &ok;

endmodule

/* src/wildcard_byte_pattern_scanner.sv */
// Top level of the wildcard byte pattern scanner.
//
//  Channel      Direction  Handshake            Payload
//  byte_stream  in         valid/ready          data_byte[7:0], last_byte
//  scan_result  out        valid/ready          match_found, match_address[47:0],
//                                               region_done
//  config       in         APB-style psel/pen   paddr[5:0], pwdata/prdata[63:0]
//
// One byte request is taken every cycle while the result side keeps up. A
// result is offered once its byte has passed three registers (input, compare,
// address add), the first of which is loaded at the edge that accepts the byte.
// Reset clears the pipeline, the position counter and the byte window and
// loads the configuration defaults (pattern length one, everything else zero).
// A stall on scan_result backs up through the stages one at a time, so the
// input is still taken while empty stages remain ahead of it.
module wildcard_byte_pattern_scanner #(
	parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	wbps_byte_if.sink                       byte_stream,
	wbps_result_if.source                   scan_result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wbps_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [wbps_pkg::APB_DATA_W-1:0] pwdata,
	output logic [wbps_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	// Longest pattern the hardware can hold.
	localparam int CAP = (PATTERN_MAX < wbps_pkg::PAT_BYTES) ? PATTERN_MAX
		: wbps_pkg::PAT_BYTES;

	wbps_pkg::cfg_t cfg;

	logic [wbps_pkg::LEN_W-1:0]  len_eff;
	logic [wbps_pkg::ADDR_W-1:0] len_wide;

	// Position counter, counting bytes of the current region.
	logic [wbps_pkg::ADDR_W-1:0] pos_q;
	logic [wbps_pkg::ADDR_W-1:0] count_next;
	logic                        in_acc;

	// Stage 1: accepted byte.
	logic                        valid_s1;
	logic [wbps_pkg::BYTE_W-1:0] byte_s1;
	logic                        last_s1;
	logic [wbps_pkg::ADDR_W-1:0] count_s1;

	// Stage 2: compare result and start offset.
	logic                        valid_s2;
	logic                        hit_s2;
	logic                        last_s2;
	logic [wbps_pkg::ADDR_W-1:0] offset_s2;

	// Stage 3: the result register.
	logic                        valid_s3;
	logic                        match_s3;
	logic [wbps_pkg::ADDR_W-1:0] address_s3;
	logic                        done_s3;

	logic                        window_hit;
	logic                        hit_s1;
	logic [wbps_pkg::ADDR_W-1:0] offset_s1;
	logic                        out_free;
	logic                        s2_free;
	logic                        s1_go;

	wbps_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// A length of zero acts as one; anything beyond the window is clamped.
	always_comb begin
		if (cfg.pattern_len == '0) begin
			len_eff = wbps_pkg::LEN_W'(1);
		end else if (cfg.pattern_len > wbps_pkg::LEN_W'(CAP)) begin
			len_eff = wbps_pkg::LEN_W'(CAP);
		end else begin
			len_eff = cfg.pattern_len;
		end
	end

	assign len_wide = wbps_pkg::ADDR_W'(len_eff);

	// Handshake chain: each stage moves on when the one after it is empty or
	// emptying in the same cycle.
	assign out_free          = !valid_s3 || scan_result.ready;
	assign s2_free           = !valid_s2 || out_free;
	assign s1_go             = valid_s1 && s2_free;
	assign byte_stream.ready = !valid_s1 || s2_free;
	assign in_acc            = byte_stream.valid && byte_stream.ready;

	// The count saturates at the top of the address range.
	assign count_next = (pos_q != wbps_pkg::ADDR_MAX) ? pos_q + wbps_pkg::ADDR_W'(1)
		: wbps_pkg::ADDR_MAX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_acc) begin
				pos_q <= byte_stream.last_byte ? '0 : count_next;
			end
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1  <= byte_stream.data_byte;
			last_s1  <= byte_stream.last_byte;
			count_s1 <= count_next;
		end
	end

	// The window shifts as each byte leaves stage 1, so the compare always
	// sees exactly the bytes that came before the one in stage 1.
	wbps_matcher #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_matcher (
		.clk           (clk),
		.arst_n        (arst_n),
		.shift_en      (s1_go),
		.cur_byte      (byte_s1),
		.pattern       (cfg.pattern),
		.wildcard_mask (cfg.wildcard_mask),
		.len_eff       (len_eff),
		.window_hit    (window_hit)
	);

	// Window bytes left over from an earlier region never count, because a
	// match needs at least len_eff bytes of the current region.
	assign offset_s1 = count_s1 - len_wide;
	assign hit_s1    = (count_s1 >= len_wide) && window_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_go) begin
			valid_s2 <= hit_s1 || last_s1;
		end else if (out_free) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			hit_s2    <= hit_s1;
			last_s2   <= last_s1;
			offset_s2 <= offset_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (valid_s2 && out_free) begin
			valid_s3 <= 1'b1;
		end else if (scan_result.ready) begin
			valid_s3 <= 1'b0;
		end
	end

	// The address wraps modulo the address width; with no match it reads zero.
	always_ff @(posedge clk) begin
		if (valid_s2 && out_free) begin
			match_s3   <= hit_s2;
			address_s3 <= hit_s2 ? cfg.base_address + offset_s2 : '0;
			done_s3    <= last_s2;
		end
	end

	assign scan_result.valid         = valid_s3;
	assign scan_result.match_found   = match_s3;
	assign scan_result.match_address = address_s3;
	assign scan_result.region_done   = done_s3;

endmodule
